// ===== sv/pmpc_pkg.sv =====
// pmpc_pkg: types and constants of the pid motor pwm controller
// no dependencies; imported by pid_motor_pwm_controller
`default_nettype none

package pmpc_pkg;

  localparam int GAIN_W     = 16;
  localparam int WINDUP_W   = 24;
  localparam int INTEG_W    = 25;
  localparam int PWM_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MEM_ADDR_W = 2;
  localparam int MEM_DEPTH  = 4;

  // divide by 100, one byte of the dividend a step
  localparam int DIGIT_W     = 8;
  localparam int REM_W       = 7;
  localparam int DIV_V_W     = REM_W + DIGIT_W;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_100   = 16'd41944;
  localparam logic [REM_W-1:0]   GAIN_SCALE  = 7'd100;

  localparam int POS_MAG_W = 7;
  localparam logic [9:0]           POS_SCALE     = 10'd1000;
  localparam logic [POS_MAG_W-1:0] POS_SAT_LIMIT = 7'd65;
  localparam logic [PWM_W-1:0]     PWM_FULL      = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_P_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_I_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_D_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_WINDUP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_P_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_I_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_D_GAIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POS_WINDUP   = 3'd7;

  localparam logic [GAIN_W-1:0]   SPEED_P_GAIN_RST = 16'd900;
  localparam logic [GAIN_W-1:0]   SPEED_I_GAIN_RST = 16'd100;
  localparam logic [GAIN_W-1:0]   SPEED_D_GAIN_RST = 16'd0;
  localparam logic [WINDUP_W-1:0] SPEED_WINDUP_RST = 24'd0;
  localparam logic [GAIN_W-1:0]   POS_P_GAIN_RST   = 16'd10;
  localparam logic [GAIN_W-1:0]   POS_I_GAIN_RST   = 16'd10;
  localparam logic [GAIN_W-1:0]   POS_D_GAIN_RST   = 16'd0;
  localparam logic [WINDUP_W-1:0] POS_WINDUP_RST   = 24'd10;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_PREP = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    T_P = 2'd0,
    T_I = 2'd1,
    T_D = 2'd2
  } term_t;

endpackage

`default_nettype wire

// ===== sv/pid_motor_pwm_controller.sv =====
// pid_motor_pwm_controller: four pid loops with integral clamp driving a pwm word
// controller state in a 4-entry synchronous memory; depends on pmpc_pkg
// each request: load, then multiply, prepare, NCH divide steps and accumulate for each of P, I, D, then output;
//   NCH = ceil((max(SAMPLE_WIDTH+2, 25)+16)/8) byte steps of the shared divide-by-100
// a new request is taken only in idle, after the last result has entered the output register
// reset: sync active-low rst_n clears control and state valid bits and loads gain and windup defaults
`default_nettype none

module pid_motor_pwm_controller #(
  parameter int SAMPLE_WIDTH = 16,
  localparam int IN_DW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_DW-1:0]                 in_tdata,   // measured, target
  input  logic [1:0]                       in_tuser,   // side, loop_mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pmpc_pkg::PWM_W-1:0]       out_tdata,  // pwm_word
  output logic [1:0]                       out_tuser,  // direction, out_side
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pmpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pmpc_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int EW     = SW + 1;
  localparam int DFW    = SW + 2;
  localparam int AW     = (DFW > INTEG_W) ? DFW : INTEG_W;
  localparam int PW     = AW + GAIN_W + 1;
  localparam int MW     = PW - 1;
  localparam int NCH    = (MW + DIGIT_W - 1) / DIGIT_W;
  localparam int QW     = NCH * DIGIT_W;
  localparam int CNT_W  = $clog2(NCH);
  localparam int ISW    = ((EW > INTEG_W) ? EW : INTEG_W) + 1;
  localparam int ACC_W  = PW + 1;
  localparam int MEM_W  = INTEG_W + EW;

  state_t state_r, state_nxt;
  term_t  term_r, term_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic signed [SW-1:0] meas_r, tgt_r;
  logic side_r, mode_r;

  logic [GAIN_W-1:0]   speed_p_gain_r, speed_i_gain_r, speed_d_gain_r;
  logic [GAIN_W-1:0]   pos_p_gain_r, pos_i_gain_r, pos_d_gain_r;
  logic [WINDUP_W-1:0] speed_windup_r, pos_windup_r;

  logic [MEM_W-1:0] mem [MEM_DEPTH];
  logic [MEM_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [MEM_DEPTH-1:0] vld_r;

  logic signed [EW-1:0]      err_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [DFW-1:0]     diff_r;
  logic signed [PW-1:0]      prod_r;
  logic [QW-1:0]             mag_r, quo_r;
  logic                      neg_r;
  logic [REM_W-1:0]          rem_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic                 out_tvalid_r;
  logic [PWM_W-1:0]     out_pwm_r;
  logic [1:0]           out_user_r;

  logic in_acc, cfg_acc, out_free;
  logic [MEM_ADDR_W-1:0] in_addr, addr_r;

  // state update datapath
  logic signed [INTEG_W-1:0]  rd_int;
  logic signed [EW-1:0]       rd_err;
  logic signed [EW-1:0]       err_nxt;
  logic signed [ISW-1:0]      integ_sum, lim_pos, lim_neg;
  logic [WINDUP_W-1:0]        lim;
  logic signed [INTEG_W-1:0]  integ_nxt;
  logic signed [DFW-1:0]      diff_nxt;

  // shared multiplier and divider
  logic signed [AW-1:0]       a_op;
  logic [GAIN_W-1:0]          gain_sel;
  logic signed [GAIN_W:0]     g_op;
  logic signed [PW-1:0]       prod_nxt;
  logic [PW-1:0]              prod_abs;
  logic [DIV_V_W-1:0]         div_v;
  logic [DIV_V_W+RECIP_W-1:0] div_p;
  logic [DIGIT_W-1:0]         div_q;
  logic [DIV_V_W-1:0]         div_r;
  logic signed [ACC_W-1:0]    q_s, acc_nxt;

  // output stage
  logic                       acc_neg;
  logic [ACC_W-1:0]           acc_abs;
  logic [POS_MAG_W+9:0]       pos_scaled;
  logic [PWM_W-1:0]           drive_mag;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign in_addr    = in_tuser;
  assign addr_r     = {mode_r, side_r};

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_pwm_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    rd_int    = rd_vld_r ? signed'(rd_data_r[MEM_W-1:EW]) : '0;
    rd_err    = rd_vld_r ? signed'(rd_data_r[EW-1:0]) : '0;
    err_nxt   = EW'(tgt_r) - EW'(meas_r);
    integ_sum = ISW'(rd_int) + ISW'(err_nxt);
    lim       = mode_r ? pos_windup_r : speed_windup_r;
    lim_pos   = signed'(ISW'(lim));
    lim_neg   = -lim_pos;
    priority if (integ_sum > lim_pos) begin
      integ_nxt = INTEG_W'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_nxt = INTEG_W'(lim_neg);
    end else begin
      integ_nxt = INTEG_W'(integ_sum);
    end
    diff_nxt = DFW'(err_nxt) - DFW'(rd_err);
  end

  always_comb begin
    unique case (term_r)
      T_P: begin
        a_op     = AW'(err_r);
        gain_sel = mode_r ? pos_p_gain_r : speed_p_gain_r;
      end
      T_I: begin
        a_op     = AW'(integ_r);
        gain_sel = mode_r ? pos_i_gain_r : speed_i_gain_r;
      end
      T_D: begin
        a_op     = AW'(diff_r);
        gain_sel = mode_r ? pos_d_gain_r : speed_d_gain_r;
      end
      default: begin
        a_op     = '0;
        gain_sel = '0;
      end
    endcase
    g_op     = signed'({1'b0, gain_sel});
    prod_nxt = a_op * g_op;
    prod_abs = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);

    div_v = {rem_r, mag_r[QW-1 -: DIGIT_W]};
    div_p = div_v * RECIP_100;
    div_q = div_p[RECIP_SHIFT +: DIGIT_W];
    div_r = div_v - DIV_V_W'(div_q) * DIV_V_W'(GAIN_SCALE);

    q_s     = signed'(ACC_W'(quo_r[MW-1:0]));
    acc_nxt = neg_r ? (acc_r - q_s) : (acc_r + q_s);
  end

  always_comb begin
    acc_neg    = acc_r[ACC_W-1];
    acc_abs    = acc_neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    pos_scaled = acc_abs[POS_MAG_W-1:0] * POS_SCALE;
    if (mode_r) begin
      drive_mag = (acc_abs > ACC_W'(POS_SAT_LIMIT)) ? PWM_FULL : pos_scaled[PWM_W-1:0];
    end else begin
      drive_mag = (acc_abs > ACC_W'(PWM_FULL)) ? PWM_FULL : acc_abs[PWM_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    unique case (term_r)
      T_P:     term_nxt = T_I;
      T_I:     term_nxt = T_D;
      default: term_nxt = T_P;
    endcase
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == CNT_W'(NCH - 1)) state_nxt = S_ACC;
      S_ACC:  state_nxt = (term_r == T_D) ? S_OUT : S_MUL;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // controller state memory
  always_ff @(posedge clk) begin
    if (in_acc) rd_data_r <= mem[in_addr];
    if (state_r == S_LOAD) mem[addr_r] <= {integ_nxt, err_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      term_r         <= T_P;
      vld_r          <= '0;
      rd_vld_r       <= 1'b0;
      out_tvalid_r   <= 1'b0;
      speed_p_gain_r <= SPEED_P_GAIN_RST;
      speed_i_gain_r <= SPEED_I_GAIN_RST;
      speed_d_gain_r <= SPEED_D_GAIN_RST;
      speed_windup_r <= SPEED_WINDUP_RST;
      pos_p_gain_r   <= POS_P_GAIN_RST;
      pos_i_gain_r   <= POS_I_GAIN_RST;
      pos_d_gain_r   <= POS_D_GAIN_RST;
      pos_windup_r   <= POS_WINDUP_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_SPEED_P_GAIN: speed_p_gain_r <= cfg_data[GAIN_W-1:0];
          REG_SPEED_I_GAIN: speed_i_gain_r <= cfg_data[GAIN_W-1:0];
          REG_SPEED_D_GAIN: speed_d_gain_r <= cfg_data[GAIN_W-1:0];
          REG_SPEED_WINDUP: speed_windup_r <= cfg_data[WINDUP_W-1:0];
          REG_POS_P_GAIN:   pos_p_gain_r   <= cfg_data[GAIN_W-1:0];
          REG_POS_I_GAIN:   pos_i_gain_r   <= cfg_data[GAIN_W-1:0];
          REG_POS_D_GAIN:   pos_d_gain_r   <= cfg_data[GAIN_W-1:0];
          REG_POS_WINDUP:   pos_windup_r   <= cfg_data[WINDUP_W-1:0];
        endcase
      end
      if (in_acc) rd_vld_r <= vld_r[in_addr];
      if (state_r == S_LOAD) begin
        vld_r[addr_r] <= 1'b1;
        term_r        <= T_P;
      end
      if (state_r == S_ACC) term_r <= term_nxt;
      if (state_r == S_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r <= signed'(in_tdata[SW-1:0]);
      tgt_r  <= signed'(in_tdata[2*SW-1:SW]);
      side_r <= in_tuser[0];
      mode_r <= in_tuser[1];
    end
    if (state_r == S_LOAD) begin
      err_r   <= err_nxt;
      integ_r <= integ_nxt;
      diff_r  <= diff_nxt;
      acc_r   <= '0;
    end
    if (state_r == S_MUL) prod_r <= prod_nxt;
    if (state_r == S_PREP) begin
      neg_r <= prod_r[PW-1];
      mag_r <= QW'(prod_abs[MW-1:0]);
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == S_DIV) begin
      mag_r <= mag_r << DIGIT_W;
      quo_r <= {quo_r[QW-DIGIT_W-1:0], div_q};
      rem_r <= div_r[REM_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == S_ACC) acc_r <= acc_nxt;
    if (state_r == S_OUT && out_free) begin
      out_pwm_r  <= PWM_FULL - drive_mag;
      out_user_r <= {side_r, acc_neg};
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_pid_motor_pwm_controller.sv =====
`timescale 1ns / 100ps
// tb_pid_motor_pwm_controller: self-checking bench for the four-loop pid pwm controller
// predicts each pwm result in a small scoreboard class and drives the stream and register
// ports with plain tasks; depends on pmpc_pkg and pid_motor_pwm_controller

module tb_pid_motor_pwm_controller;
  import pmpc_pkg::*;

  localparam int     SW            = 16;
  localparam longint GAIN_DIVISOR  = 100;
  localparam longint POSITION_GAIN = 1000;
  localparam longint DRIVE_MAX     = 65535;
  localparam bit     SIDE_RIGHT    = 1'b0;
  localparam bit     SIDE_LEFT     = 1'b1;
  localparam bit     SPEED_LOOP    = 1'b0;
  localparam bit     POSITION_LOOP = 1'b1;
  localparam int     LATENCY       = 29;
  localparam int     PHASES        = 12;
  localparam int     PHASE_SAMPLES = 138;
  localparam int     LONG_HOLD     = 500;

  localparam int PROFILE_MAX       = 0;
  localparam int PROFILE_ZERO      = 1;
  localparam int PROFILE_MILD      = 2;
  localparam int PROFILE_WIDE      = 3;
  localparam int PROFILE_NO_WINDUP = 4;

  typedef struct {
    logic [PWM_W-1:0] pwm;
    bit               backward;
    bit               side;
  } drive_t;

  class motor_drive_board;
    longint setting [8];
    longint integral [4];
    longint last_error [4];
    drive_t drive_q [$];
    int     fails;

    function new();
      setting[REG_SPEED_P_GAIN] = longint'(SPEED_P_GAIN_RST);
      setting[REG_SPEED_I_GAIN] = longint'(SPEED_I_GAIN_RST);
      setting[REG_SPEED_D_GAIN] = longint'(SPEED_D_GAIN_RST);
      setting[REG_SPEED_WINDUP] = longint'(SPEED_WINDUP_RST);
      setting[REG_POS_P_GAIN]   = longint'(POS_P_GAIN_RST);
      setting[REG_POS_I_GAIN]   = longint'(POS_I_GAIN_RST);
      setting[REG_POS_D_GAIN]   = longint'(POS_D_GAIN_RST);
      setting[REG_POS_WINDUP]   = longint'(POS_WINDUP_RST);
      foreach (integral[i]) begin
        integral[i]   = 0;
        last_error[i] = 0;
      end
      fails = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SPEED_WINDUP || idx == REG_POS_WINDUP) begin
        setting[idx] = longint'(data[WINDUP_W-1:0]);
      end else begin
        setting[idx] = longint'(data[GAIN_W-1:0]);
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    function void accept_sample(logic signed [SW-1:0] meas, logic signed [SW-1:0] tgt,
                                bit side, bit mode);
      longint kp, ki, kd, lim, err, acc, sum, mag;
      int     slot;
      drive_t d;
      slot = int'({mode, side});
      kp  = mode ? setting[REG_POS_P_GAIN] : setting[REG_SPEED_P_GAIN];
      ki  = mode ? setting[REG_POS_I_GAIN] : setting[REG_SPEED_I_GAIN];
      kd  = mode ? setting[REG_POS_D_GAIN] : setting[REG_SPEED_D_GAIN];
      lim = mode ? setting[REG_POS_WINDUP] : setting[REG_SPEED_WINDUP];
      err = longint'(tgt) - longint'(meas);
      sum = err * kp / GAIN_DIVISOR;
      acc = integral[slot] + err;
      if (acc > lim) begin
        acc = lim;
      end else if (acc < -lim) begin
        acc = -lim;
      end
      integral[slot] = acc;
      sum += acc * ki / GAIN_DIVISOR;
      sum += (err - last_error[slot]) * kd / GAIN_DIVISOR;
      last_error[slot] = err;
      if (mode == POSITION_LOOP) begin
        sum *= POSITION_GAIN;
      end
      d.backward = (sum < 0);
      mag = d.backward ? -sum : sum;
      if (mag > DRIVE_MAX) begin
        mag = DRIVE_MAX;
      end
      d.pwm  = PWM_W'(DRIVE_MAX - mag);
      d.side = side;
      drive_q.push_back(d);
    endfunction

    function void check_drive(logic [PWM_W-1:0] pwm, logic backward, logic side);
      drive_t d;
      if (drive_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected result pwm %h dir %b side %b", $time, pwm, backward, side);
        return;
      end
      d = drive_q.pop_front();
      if (pwm !== d.pwm) begin
        fails++;
        $display("%0t: pwm_word expected %h actual %h", $time, d.pwm, pwm);
      end
      if (backward !== d.backward) begin
        fails++;
        $display("%0t: direction expected %b actual %b", $time, d.backward, backward);
      end
      if (side !== d.side) begin
        fails++;
        $display("%0t: out_side expected %b actual %b", $time, d.side, side);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [2*SW-1:0]       in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PWM_W-1:0]      out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  logic [CFG_DATA_W-1:0] next_regs [8];
  int                    tx_idle_pct  = 0;
  int                    rx_stall_pct = 0;
  bit                    hold_req     = 1'b0;
  int                    hold_left    = 0;
  motor_drive_board      board;

  pid_motor_pwm_controller #(.SAMPLE_WIDTH(SW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // result side: checks, random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_drive(out_tdata, out_tuser[0], out_tuser[1]);
    end
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_sample(input logic signed [SW-1:0] meas, input logic signed [SW-1:0] tgt,
                             input bit side, input bit mode);
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {tgt, meas};
    in_tuser  <= {mode, side};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.accept_sample(meas, tgt, side, mode);
  endtask

  task automatic random_sample();
    logic signed [SW-1:0] meas, tgt;
    bit                   side, mode;
    int                   delta;
    meas = SW'($urandom);
    side = 1'($urandom_range(1));
    mode = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1, 2: tgt = SW'($urandom);
      3, 4, 5, 6: begin
        delta = int'($urandom_range(400)) - 200;
        tgt   = SW'(meas + delta);
      end
      7: begin
        delta = int'($urandom_range(20)) - 10;
        tgt   = SW'(meas + delta);
      end
      8: begin
        meas = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
        tgt  = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      default: tgt = meas;
    endcase
    send_sample(meas, tgt, side, mode);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, data);
  endtask

  task automatic plan_settings(input int profile);
    logic [GAIN_W-1:0]   g;
    logic [WINDUP_W-1:0] w;
    foreach (next_regs[i]) begin
      case (profile)
        PROFILE_MAX: begin
          g = '1;
          w = '1;
        end
        PROFILE_ZERO: begin
          g = '0;
          w = '0;
        end
        PROFILE_MILD: begin
          g = GAIN_W'($urandom_range(300));
          w = WINDUP_W'($urandom_range(3000));
        end
        PROFILE_NO_WINDUP: begin
          g = GAIN_W'($urandom_range(2000));
          w = '0;
        end
        default: begin
          g = GAIN_W'($urandom);
          w = WINDUP_W'($urandom);
        end
      endcase
      next_regs[i] = CFG_DATA_W'($urandom);
      if (i == REG_SPEED_WINDUP || i == REG_POS_WINDUP) begin
        next_regs[i] = w;
      end else begin
        next_regs[i][GAIN_W-1:0] = g;
      end
    end
  endtask

  task automatic load_settings();
    write_reg(REG_SPEED_P_GAIN, next_regs[REG_SPEED_P_GAIN]);
    write_reg(REG_SPEED_I_GAIN, next_regs[REG_SPEED_I_GAIN]);
    write_reg(REG_SPEED_D_GAIN, next_regs[REG_SPEED_D_GAIN]);
    write_reg(REG_SPEED_WINDUP, next_regs[REG_SPEED_WINDUP]);
    write_reg(REG_POS_P_GAIN, next_regs[REG_POS_P_GAIN]);
    write_reg(REG_POS_I_GAIN, next_regs[REG_POS_I_GAIN]);
    write_reg(REG_POS_D_GAIN, next_regs[REG_POS_D_GAIN]);
    write_reg(REG_POS_WINDUP, next_regs[REG_POS_WINDUP]);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains: zero speed windup, position truncation and clamp
    send_sample(16'sd0, 16'sd0, SIDE_RIGHT, SPEED_LOOP);
    send_sample(16'sh8000, 16'sh7FFF, SIDE_RIGHT, SPEED_LOOP);
    send_sample(16'sh7FFF, 16'sh8000, SIDE_LEFT, SPEED_LOOP);
    send_sample(16'sd0, -16'sd1, SIDE_RIGHT, POSITION_LOOP);
    send_sample(16'sd0, 16'sd20, SIDE_LEFT, POSITION_LOOP);
    send_sample(16'sd0, 16'sd20, SIDE_LEFT, POSITION_LOOP);
    send_sample(16'sd100, -16'sd100, SIDE_RIGHT, POSITION_LOOP);
    send_sample(16'sd10, 16'sd17, SIDE_RIGHT, SPEED_LOOP);
    send_sample(16'sd5, 16'sd2, SIDE_LEFT, SPEED_LOOP);
    drain();

    // full-scale gains and windup limits
    plan_settings(PROFILE_MAX);
    load_settings();
    send_sample(16'sh8000, 16'sh7FFF, SIDE_RIGHT, SPEED_LOOP);
    send_sample(16'sh7FFF, 16'sh8000, SIDE_RIGHT, SPEED_LOOP);
    send_sample(16'sd0, 16'sd1, SIDE_LEFT, POSITION_LOOP);
    send_sample(16'sd3, 16'sd3, SIDE_LEFT, SPEED_LOOP);
    send_sample(16'sh7FFF, 16'sh8000, SIDE_RIGHT, POSITION_LOOP);
    send_sample(-16'sd1, -16'sd1, SIDE_RIGHT, SPEED_LOOP);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: plan_settings(PROFILE_ZERO);
        1: plan_settings(PROFILE_MAX);
        default: plan_settings(PROFILE_MILD + p % 3);
      endcase
      load_settings();
      if (p == 5) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req = 1'b1;
        repeat (24) random_sample();
        drain();
      end
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 85;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 85;
        end
        default: begin
          tx_idle_pct  = 6;
          rx_stall_pct = 6;
        end
      endcase
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (p % 2 == 1 && i == PHASE_SAMPLES / 2) begin
          drain();
        end
        random_sample();
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (board.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pmpc_pkg.sv
sv/pid_motor_pwm_controller.sv
dv/tb_pid_motor_pwm_controller.sv
